@@ hdl/dcgc_pkg.sv @@
package dcgc_pkg;

    localparam int MAX_CHANNELS_DEFAULT = 32;

    localparam int KIND_W    = 2;
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 8;
    localparam int CHAN_W    = 5;
    localparam int DUTY_W    = 16;
    localparam int TARGET_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

    localparam logic [1:0] RES_STATUS    = 2'd0;
    localparam logic [1:0] RES_HEARTBEAT = 2'd1;
    localparam logic [1:0] RES_DUTY      = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CHANNEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_OFF      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY_ID    = 2'd3;

    localparam logic [TIME_W-1:0]  HEARTBEAT_MS = 32'd3000;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 8'd100;
    localparam logic [LEVEL_W-1:0] RESET_LEVEL  = 8'd50;
    localparam logic [DUTY_W-1:0]  FULL_DUTY    = 16'hFFFF;

    // floor(x / 100) = (x * ceil(2^30 / 100)) >> 30 for every x below 2^23.
    localparam int RECIP_W = 24;
    localparam int SCALED_W = 23;
    localparam int PROD_W = SCALED_W + RECIP_W;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] DUTY_RECIP = 24'd10737419;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMD  = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_HB   = 5'b01000,
        ST_CH   = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_item;
        logic emit_cmd;
        logic eval;
        logic emit_hb;
        logic emit_ch;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_cmd;
        logic hb_eval;
        logic wr_eval;
        logic wr_pend;
        logic ch_end;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/dcgc_ctrl.sv @@
module dcgc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  dcgc_pkg::dp_status_t  status,
    output dcgc_pkg::ctrl_cmd_t   cmd
);

    dcgc_pkg::state_t state_reg;
    dcgc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcgc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == dcgc_pkg::ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            dcgc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next = status.in_is_cmd ? dcgc_pkg::ST_CMD : dcgc_pkg::ST_EVAL;
                end
            end
            dcgc_pkg::ST_CMD: begin
                if (status.out_free) begin
                    cmd.emit_cmd = 1'b1;
                    state_next = dcgc_pkg::ST_IDLE;
                end
            end
            dcgc_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.hb_eval) begin
                    state_next = dcgc_pkg::ST_HB;
                end else if (status.wr_eval) begin
                    state_next = dcgc_pkg::ST_CH;
                end else begin
                    state_next = dcgc_pkg::ST_IDLE;
                end
            end
            dcgc_pkg::ST_HB: begin
                if (status.out_free) begin
                    cmd.emit_hb = 1'b1;
                    state_next = status.wr_pend ? dcgc_pkg::ST_CH : dcgc_pkg::ST_IDLE;
                end
            end
            dcgc_pkg::ST_CH: begin
                if (status.out_free) begin
                    cmd.emit_ch = 1'b1;
                    if (status.ch_end) begin
                        state_next = dcgc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = dcgc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/dcgc_dp.sv @@
module dcgc_dp #(
    parameter int MAX_CHANNELS = dcgc_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dcgc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [dcgc_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcgc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [dcgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcgc_pkg::CFG_DAT_W-1:0]    cfg_wr_data,
    input  dcgc_pkg::ctrl_cmd_t               cmd,
    output dcgc_pkg::dp_status_t              status
);

    localparam logic [dcgc_pkg::CHAN_W:0] MaxCh = (dcgc_pkg::CHAN_W + 1)'(MAX_CHANNELS);

    logic [dcgc_pkg::CHAN_W-1:0]   first_reg;
    logic [dcgc_pkg::CHAN_W-1:0]   last_reg;
    logic [dcgc_pkg::TIME_W-1:0]   auto_off_reg;
    logic [dcgc_pkg::TARGET_W-1:0] target_reg;

    logic                          light_on_reg;
    logic                          pending_reg;
    logic [dcgc_pkg::LEVEL_W-1:0]  level_reg;
    logic [dcgc_pkg::TIME_W-1:0]   last_change_reg;
    logic [dcgc_pkg::TIME_W-1:0]   last_hb_reg;

    logic [dcgc_pkg::KIND_W-1:0]   kind_reg;
    logic [dcgc_pkg::TIME_W-1:0]   now_reg;
    logic [dcgc_pkg::LEVEL_W-1:0]  req_reg;
    logic [dcgc_pkg::PROD_W-1:0]   prod_reg;
    logic [dcgc_pkg::CHAN_W-1:0]   chan_reg;
    logic                          wr_pend_reg;

    logic                          out_valid_reg;
    logic [1:0]                    out_type_reg;
    logic                          out_status_reg;
    logic [dcgc_pkg::TARGET_W-1:0] out_target_reg;
    logic [dcgc_pkg::CHAN_W-1:0]   out_chan_reg;
    logic [dcgc_pkg::DUTY_W-1:0]   out_duty_reg;
    logic                          out_last_reg;

    logic                          auto_off;
    logic                          light_after;
    logic                          pending_after;
    logic                          group_valid;
    logic                          hb_due;
    logic [dcgc_pkg::SCALED_W-1:0] scaled;
    logic [dcgc_pkg::DUTY_W-1:0]   duty;
    logic                          out_free;

    assign out_free = !out_valid_reg || m_tready;

    assign auto_off = light_on_reg && (auto_off_reg != '0)
                      && ((now_reg - last_change_reg) >= auto_off_reg);
    assign light_after   = light_on_reg && !auto_off;
    assign pending_after = pending_reg || auto_off;
    assign hb_due = light_after && ((now_reg - last_hb_reg) > dcgc_pkg::HEARTBEAT_MS);
    assign group_valid = (first_reg <= last_reg) && ({1'b0, first_reg} < MaxCh);

    assign scaled = {level_reg[6:0], 16'h0000} - {16'h0000, level_reg[6:0]};

    always_comb begin
        if (!light_on_reg) begin
            duty = '0;
        end else if (level_reg >= dcgc_pkg::FULL_LEVEL) begin
            duty = dcgc_pkg::FULL_DUTY;
        end else begin
            duty = prod_reg[dcgc_pkg::RECIP_SHIFT +: dcgc_pkg::DUTY_W];
        end
    end

    assign status.in_is_cmd = (s_tuser != dcgc_pkg::KIND_TICK);
    assign status.hb_eval   = hb_due;
    assign status.wr_eval   = pending_after && group_valid;
    assign status.wr_pend   = wr_pend_reg;
    assign status.ch_end    = (chan_reg == last_reg)
                              || (({1'b0, chan_reg} + 1'b1) == MaxCh);
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg    <= '0;
            last_reg     <= '0;
            auto_off_reg <= '0;
            target_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcgc_pkg::REG_FIRST_CHANNEL: first_reg    <= cfg_wr_data[dcgc_pkg::CHAN_W-1:0];
                dcgc_pkg::REG_LAST_CHANNEL:  last_reg     <= cfg_wr_data[dcgc_pkg::CHAN_W-1:0];
                dcgc_pkg::REG_AUTO_OFF:      auto_off_reg <= cfg_wr_data;
                dcgc_pkg::REG_STANDBY_ID:    target_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= s_tuser;
            now_reg  <= s_tdata[dcgc_pkg::TIME_W-1:0];
            req_reg  <= s_tdata[dcgc_pkg::TIME_W +: dcgc_pkg::LEVEL_W];
        end
        if (cmd.eval) begin
            prod_reg    <= scaled * dcgc_pkg::DUTY_RECIP;
            chan_reg    <= first_reg;
            wr_pend_reg <= pending_after && group_valid;
        end else if (cmd.emit_ch) begin
            chan_reg <= chan_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_on_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            level_reg       <= dcgc_pkg::RESET_LEVEL;
            last_change_reg <= '0;
            last_hb_reg     <= '0;
        end else if (cmd.emit_cmd) begin
            case (kind_reg)
                dcgc_pkg::KIND_TOGGLE: begin
                    light_on_reg <= !light_on_reg;
                    pending_reg  <= 1'b1;
                end
                dcgc_pkg::KIND_SET: begin
                    level_reg   <= req_reg;
                    pending_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (cmd.eval) begin
            light_on_reg <= light_after;
            if (hb_due) begin
                last_hb_reg <= now_reg;
            end
            if (pending_after) begin
                pending_reg     <= 1'b0;
                last_change_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_cmd || cmd.emit_hb || cmd.emit_ch) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_cmd) begin
            out_type_reg   <= dcgc_pkg::RES_STATUS;
            out_status_reg <= (kind_reg == dcgc_pkg::KIND_BAD) ? dcgc_pkg::STATUS_INVALID
                                                                : dcgc_pkg::STATUS_OK;
            out_target_reg <= '0;
            out_chan_reg   <= '0;
            out_duty_reg   <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_hb) begin
            out_type_reg   <= dcgc_pkg::RES_HEARTBEAT;
            out_status_reg <= dcgc_pkg::STATUS_OK;
            out_target_reg <= target_reg;
            out_chan_reg   <= '0;
            out_duty_reg   <= '0;
            out_last_reg   <= !wr_pend_reg;
        end else if (cmd.emit_ch) begin
            out_type_reg   <= dcgc_pkg::RES_DUTY;
            out_status_reg <= dcgc_pkg::STATUS_OK;
            out_target_reg <= '0;
            out_chan_reg   <= chan_reg;
            out_duty_reg   <= duty;
            out_last_reg   <= status.ch_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_type_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_duty_reg, out_chan_reg, out_target_reg, out_status_reg};

endmodule

@@ hdl/dimmer_channel_group_controller.sv @@
// Dimmer for a group of PWM channels. Each input transfer is a command (toggle, set intensity,
// or an unsupported code) or a tick carrying the millisecond time. A command is loaded and then
// returns one status transfer. A tick is loaded and then evaluated for auto-off, heartbeat and
// pending change; its results then leave one per cycle while the result side does not stall:
// an optional heartbeat request and, when a change is pending and the group is valid, one duty
// write per channel from first_channel to last_channel, stopping at MAX_CHANNELS-1. The single
// output register and the controller sequencing one result per cycle bound the rate; a new
// input transfer is taken once the last result of the previous one sits in the output register.
module dimmer_channel_group_controller #(
    parameter int MAX_CHANNELS = dcgc_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms [31:0], new_intensity [39:32]
    input  logic [dcgc_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind [1:0]
    input  logic [dcgc_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [0], heartbeat_target [32:1], channel [37:33], duty [53:38], zero [55:54]
    output logic [dcgc_pkg::M_TDATA_W-1:0]    m_tdata,
    // result_type [1:0]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [dcgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcgc_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);

    dcgc_pkg::ctrl_cmd_t  cmd;
    dcgc_pkg::dp_status_t status;

    dcgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dcgc_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

@@ hdl/dcgc_checker.sv @@
module dcgc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dcgc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);

    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
            (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input taken again right after a transfer");

    property p_status_is_last;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && (m_tuser == dcgc_pkg::RES_STATUS)) |-> m_tlast;
    endproperty
    a_status_is_last: assert property (p_status_is_last)
        else $error("status result without tlast");

    property p_heartbeat_clean;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && (m_tuser == dcgc_pkg::RES_HEARTBEAT))
                |-> (m_tdata[0] == 1'b0) && (m_tdata[55:33] == '0);
    endproperty
    a_heartbeat_clean: assert property (p_heartbeat_clean)
        else $error("heartbeat result carries channel or duty bits");

    property p_result_held;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
    endproperty
    a_result_held: assert property (p_result_held)
        else $error("stalled result changed");

endmodule

bind dimmer_channel_group_controller dcgc_checker u_dcgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
